// ===== sv/srie_pkg.sv =====
// Shared types and constants for the small RISC instruction executor.
package srie_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_MOVI = 4'd3,
    OP_JEQ  = 4'd4,
    OP_AND  = 4'd5,
    OP_XORI = 4'd6,
    OP_JMP  = 4'd7,
    OP_LSL  = 4'd8,
    OP_LSR  = 4'd9,
    OP_MOVR = 4'd10,
    OP_MOVM = 4'd11
  } op_e;

  localparam int unsigned OpLsb = 28;
  localparam int unsigned OutAddrW = 10;
  localparam int unsigned OutPcW = 11;

  typedef struct packed {
    logic        halt;
    logic        nop;
    logic [3:0]  op;
    logic [4:0]  r1;
    logic [4:0]  r2;
    logic [4:0]  r3;
    logic [17:0] imm;
    logic [12:0] shamt;
    logic [27:0] jaddr;
  } dec_t;

endpackage

// ===== sv/srie_front.sv =====
// Front end: accepts instruction beats, decodes them and queues them for execution.
module srie_front import srie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_i,
  output logic        dec_valid_o,
  input  logic        dec_ready_i,
  output dec_t        dec_o
);

  dec_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  dec_t       d;
  logic       push, pop;

  always_comb begin
    d.halt  = (instr_i == 32'd0);
    d.op    = instr_i[31:OpLsb];
    d.nop   = (instr_i[31:OpLsb] > OP_MOVM);
    d.r1    = instr_i[27:23];
    d.r2    = instr_i[22:18];
    d.r3    = instr_i[17:13];
    d.imm   = instr_i[17:0];
    d.shamt = instr_i[12:0];
    d.jaddr = instr_i[27:0];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign dec_valid_o = (cnt_q != 2'd0);
  assign dec_o       = q_mem[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = dec_valid_o && dec_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/srie_back.sv =====
// Back end: executes decoded instructions against registers and data memory.
module srie_back import srie_pkg::*; #(
  parameter int unsigned DataWords = 1024,
  parameter int unsigned ProgramWords = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dec_valid_i,
  output logic              dec_ready_o,
  input  dec_t              dec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OutPcW-1:0] next_pc_o,
  output logic              reg_write_o,
  output logic [4:0]        dest_reg_o,
  output logic signed [31:0] write_value_o,
  output logic              mem_write_o,
  output logic [OutAddrW-1:0] mem_address_o,
  output logic              halted_o
);

  localparam int unsigned AW = $clog2(DataWords);
  localparam int unsigned PW = $clog2(ProgramWords);

  logic [31:0] rf_q [32];
  logic [31:0] mem [DataWords];
  logic [31:0] mem_rd_q;
  logic [PW-1:0] pc_q;
  logic halt_q;

  // stage 2 (result) registers
  logic        s2_valid_q, s2_load_q, s2_wr_q, s2_mw_q, s2_halt_q;
  logic [4:0]  s2_dst_q;
  logic [31:0] s2_val_q;
  logic [AW-1:0] s2_addr_q;
  logic [PW-1:0] s2_pc_q;

  logic fire;
  logic ld_commit;
  logic [31:0] a, b, c, val, sum;
  logic [AW-1:0] addr;
  logic [PW-1:0] nxt;
  logic wr, mw, load, hz;

  logic [AW:0] clr_q;
  logic clr_busy;

  assign clr_busy = !clr_q[AW];
  assign dec_ready_o = !clr_busy && (!s2_valid_q || out_ready_i);
  assign fire = dec_valid_i && dec_ready_o;
  assign ld_commit = s2_valid_q && s2_load_q && out_ready_i;

  // forward the pending result (loaded or computed) from the result stage
  function automatic logic [31:0] rd(input logic [4:0] r, input logic [31:0] f);
    logic [31:0] v;
    v = rf_q[r];
    if (s2_valid_q && s2_wr_q && s2_dst_q == r) v = f;
    return v;
  endfunction

  logic [31:0] fwd;
  assign fwd = s2_load_q ? mem_rd_q : s2_val_q;

  always_comb begin
    a = rd(dec_i.r2, fwd);
    b = rd(dec_i.r3, fwd);
    c = rd(dec_i.r1, fwd);
    sum = a + 32'(dec_i.imm);
    addr = sum[AW-1:0];
    nxt = pc_q + PW'(1);
    val = '0; wr = 1'b0; mw = 1'b0; load = 1'b0;
    hz = halt_q || dec_i.halt;
    if (hz) begin
      nxt = pc_q;
    end else if (!dec_i.nop) begin
      case (op_e'(dec_i.op))
        OP_ADD:  begin val = a + b; wr = 1'b1; end
        OP_SUB:  begin val = a - b; wr = 1'b1; end
        OP_MUL:  begin val = a * b; wr = 1'b1; end
        OP_MOVI: begin val = 32'(dec_i.imm); wr = 1'b1; end
        OP_JEQ:  if (c == a) nxt = pc_q + PW'(dec_i.imm);
        OP_AND:  begin val = a & b; wr = 1'b1; end
        OP_XORI: begin val = a ^ 32'(dec_i.imm); wr = 1'b1; end
        OP_JMP:  nxt = dec_i.jaddr[PW-1:0] - PW'(1);
        OP_LSL:  begin val = (dec_i.shamt >= 13'd32) ? '0 : a << dec_i.shamt[4:0];
                   wr = 1'b1; end
        OP_LSR:  begin val = (dec_i.shamt >= 13'd32) ? '0 : a >> dec_i.shamt[4:0];
                   wr = 1'b1; end
        OP_MOVR: begin wr = 1'b1; load = 1'b1; end
        OP_MOVM: mw = (dec_i.r1 != 5'd0);
        default: ;
      endcase
      if (dec_i.r1 == 5'd0) begin wr = 1'b0; load = 1'b0; end
    end
  end

  // data memory: one write, one registered read; zeroed by a pass after reset
  always_ff @(posedge clk_i) begin
    if (clr_busy) mem[clr_q[AW-1:0]] <= '0;
    else if (fire && !hz && mw) mem[addr] <= c;
    if (fire) mem_rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      pc_q <= '0;
      halt_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_load_q <= 1'b0;
      s2_wr_q <= 1'b0;
      s2_mw_q <= 1'b0;
      s2_halt_q <= 1'b0;
      s2_dst_q <= '0;
      s2_val_q <= '0;
      s2_addr_q <= '0;
      s2_pc_q <= '0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      if (clr_busy) clr_q <= clr_q + (AW+1)'(1);
      if (fire) begin
        s2_valid_q <= 1'b1;
        pc_q <= nxt;
        halt_q <= hz;
        s2_load_q <= load;
        s2_wr_q <= wr;
        s2_mw_q <= mw;
        s2_halt_q <= hz;
        s2_dst_q <= wr ? dec_i.r1 : 5'd0;
        s2_val_q <= wr ? val : '0;
        s2_addr_q <= (!hz && (op_e'(dec_i.op) == OP_MOVR || op_e'(dec_i.op) == OP_MOVM)
                      && !dec_i.nop) ? addr : '0;
        s2_pc_q <= nxt;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
      // a new write wins over a pending load to the same register
      for (int i = 0; i < 32; i++) begin
        if (fire && wr && !load && dec_i.r1 == 5'(i)) rf_q[i] <= val;
        else if (ld_commit && s2_dst_q == 5'(i)) rf_q[i] <= mem_rd_q;
      end
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign next_pc_o     = OutPcW'(s2_pc_q);
  assign reg_write_o   = s2_wr_q;
  assign dest_reg_o    = s2_dst_q;
  assign write_value_o = s2_load_q ? mem_rd_q : s2_val_q;
  assign mem_write_o   = s2_mw_q;
  assign mem_address_o = OutAddrW'(s2_addr_q);
  assign halted_o      = s2_halt_q;

endmodule

// ===== sv/small_risc_instruction_executor_unit.sv =====
// Top level of the small RISC instruction executor.
// One instruction per clock when both sides flow: a two-entry decode queue feeds an
// execute stage that registers the result; loads read the data memory in that stage
// and are forwarded. An accepted beat waits in the decode queue and then in the result
// registers before it leaves. After reset a clearing pass zeroes the data memory; the
// queue takes up to two instructions meanwhile, but none executes until the pass ends.
module small_risc_instruction_executor_unit import srie_pkg::*; #(
  parameter int unsigned DATA_WORDS = 1024,
  parameter int unsigned PROGRAM_WORDS = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        next_pc_o,
  output logic               reg_write_o,
  output logic [4:0]         dest_reg_o,
  output logic signed [31:0] write_value_o,
  output logic               mem_write_o,
  output logic [9:0]         mem_address_o,
  output logic               halted_o
);

  dec_t dec;
  logic dec_valid, dec_ready;

  srie_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .instr_i,
    .dec_valid_o(dec_valid), .dec_ready_i(dec_ready), .dec_o(dec)
  );

  srie_back #(.DataWords(DATA_WORDS), .ProgramWords(PROGRAM_WORDS)) u_back (
    .clk_i, .rst_ni, .dec_valid_i(dec_valid), .dec_ready_o(dec_ready), .dec_i(dec),
    .out_valid_o, .out_ready_i, .next_pc_o, .reg_write_o, .dest_reg_o,
    .write_value_o, .mem_write_o, .mem_address_o, .halted_o
  );

endmodule

// ===== sv/srie_checker.sv =====
// Port-level checks for the small RISC instruction executor.
module srie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        reg_write_o,
  input logic [4:0]  dest_reg_o,
  input logic        mem_write_o,
  input logic        halted_o,
  input logic [10:0] next_pc_o
);

  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_write_o |-> dest_reg_o != 5'd0) else $error("write to r0");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_write_o && mem_write_o)) else $error("reg and mem write");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> !reg_write_o && !mem_write_o) else $error("halted write");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_pc_o))
    else $error("result dropped");

endmodule

bind small_risc_instruction_executor_unit srie_checker u_chk (.*);
